// File: hdl/tlpc_pkg.sv
package tlpc_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	localparam logic [CFG_W-1:0] GREEN_RST = CFG_W'(10000);
	localparam logic [CFG_W-1:0] MIN_GREEN_RST = CFG_W'(5000);
	localparam logic [CFG_W-1:0] YELLOW_RST = CFG_W'(3000);
	localparam logic [CFG_W-1:0] ALL_RED_RST = CFG_W'(10000);
	localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(200);

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef enum logic [2:0] {
		PH_R1_GREEN  = 3'd0,
		PH_R1_YELLOW = 3'd1,
		PH_ALL_RED   = 3'd2,
		PH_R2_GREEN  = 3'd3,
		PH_R2_YELLOW = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GREEN    = 3'd0,
		REG_MIN_GRN  = 3'd1,
		REG_YELLOW   = 3'd2,
		REG_ALL_RED  = 3'd3,
		REG_DEBOUNCE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic r1_red;
		logic r1_yellow;
		logic r1_green;
		logic r2_red;
		logic r2_green;
	} lamps_t;

	typedef struct packed {
		lamps_t lamps;
		phase_t ph;
		logic   req;
		logic   changed;
	} result_t;

	function automatic lamps_t lamp_decode(input phase_t ph);
		lamps_t l;
		l = '0;
		case (ph)
			PH_R1_GREEN:  l = '{r1_red: 1'b0, r1_yellow: 1'b0, r1_green: 1'b1,
				r2_red: 1'b1, r2_green: 1'b0};
			PH_R1_YELLOW: l = '{r1_red: 1'b0, r1_yellow: 1'b1, r1_green: 1'b0,
				r2_red: 1'b1, r2_green: 1'b0};
			PH_ALL_RED:   l = '{r1_red: 1'b1, r1_yellow: 1'b0, r1_green: 1'b0,
				r2_red: 1'b1, r2_green: 1'b0};
			PH_R2_GREEN:  l = '{r1_red: 1'b1, r1_yellow: 1'b0, r1_green: 1'b0,
				r2_red: 1'b0, r2_green: 1'b1};
			PH_R2_YELLOW: l = '{r1_red: 1'b1, r1_yellow: 1'b1, r1_green: 1'b0,
				r2_red: 1'b1, r2_green: 1'b0};
			default:      l = '0;
		endcase
		return l;
	endfunction

	function automatic timer_t sat_inc(input timer_t v);
		return (v == '1) ? v : v + timer_t'(1);
	endfunction

endpackage

// File: hdl/traffic_light_pedestrian_controller.sv
// channel | signals                          | transaction
// tick in | in_valid, in_ready, button_edge  | one millisecond tick
// lamps   | out_valid, out_ready, lamp/phase | lamp state after that tick
// config  | cfg_we, cfg_index, cfg_wdata     | one register write, no wait
//
// one tick per clock while in_ready is high; the phase, timers and request update in the accept cycle
// and the result is registered, in the output register or, when the output is stalled, in the skid
// results queue two deep (output register plus skid), in_ready falls only when both are full
// reset puts all timers to zero, phase to road1 green and registers to defaults
module traffic_light_pedestrian_controller import tlpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 button_edge,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 road1_red,
	output logic                 road1_amber,
	output logic                 road1_go,
	output logic                 road2_red,
	output logic                 road2_go,
	output logic [2:0]           phase,
	output logic                 request_pending,
	output logic                 phase_changed
);

	logic [CFG_W-1:0] green_q, min_green_q, yellow_q, all_red_q, debounce_q;

	phase_t  phase_q, phase_d;
	timer_t  tip_q, tsp_q, tip_d, tsp_d, tip_inc, tsp_inc;
	logic    req_q, req_d, press_ok, done;
	result_t res_d, out_q, skid_q;
	logic    out_valid_q, skid_valid_q, push, pop;

	assign in_ready = !skid_valid_q;
	assign push = in_valid && in_ready;
	assign pop = out_valid_q && out_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_q <= GREEN_RST;
			min_green_q <= MIN_GREEN_RST;
			yellow_q <= YELLOW_RST;
			all_red_q <= ALL_RED_RST;
			debounce_q <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GREEN:    green_q <= cfg_wdata;
				REG_MIN_GRN:  min_green_q <= cfg_wdata;
				REG_YELLOW:   yellow_q <= cfg_wdata;
				REG_ALL_RED:  all_red_q <= cfg_wdata;
				REG_DEBOUNCE: debounce_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// next state for one tick
	always_comb begin
		tip_inc = sat_inc(tip_q);
		tsp_inc = sat_inc(tsp_q);
		press_ok = button_edge && (CMP_W'(tsp_inc) > CMP_W'(debounce_q));
		req_d = req_q || press_ok;
		tsp_d = press_ok ? '0 : tsp_inc;
		phase_d = phase_q;
		done = 1'b0;
		case (phase_q)
			PH_R1_GREEN: begin
				done = (CMP_W'(tip_inc) >= CMP_W'(green_q)) ||
					(req_d && (CMP_W'(tip_inc) >= CMP_W'(min_green_q)));
				if (done) begin
					req_d = 1'b0;
					phase_d = PH_R1_YELLOW;
				end
			end
			PH_R1_YELLOW: begin
				done = CMP_W'(tip_inc) >= CMP_W'(yellow_q);
				if (done) phase_d = PH_ALL_RED;
			end
			PH_ALL_RED: begin
				done = CMP_W'(tip_inc) >= CMP_W'(all_red_q);
				if (done) phase_d = PH_R2_GREEN;
			end
			PH_R2_GREEN: begin
				done = CMP_W'(tip_inc) >= CMP_W'(green_q);
				if (done) phase_d = PH_R2_YELLOW;
			end
			PH_R2_YELLOW: begin
				done = CMP_W'(tip_inc) >= CMP_W'(yellow_q);
				if (done) phase_d = PH_R1_GREEN;
			end
			default: begin
				done = 1'b1;
				phase_d = PH_R1_GREEN;
			end
		endcase
		tip_d = (phase_d != phase_q) ? '0 : tip_inc;
		res_d.lamps = lamp_decode(phase_d);
		res_d.ph = phase_d;
		res_d.req = req_d;
		res_d.changed = phase_d != phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_R1_GREEN;
			tip_q <= '0;
			tsp_q <= '0;
			req_q <= 1'b0;
		end else if (push) begin
			phase_q <= phase_d;
			tip_q <= tip_d;
			tsp_q <= tsp_d;
			req_q <= req_d;
		end
	end

	// result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_d;
			end
		end else if (!out_valid_q) begin
			if (push) out_q <= res_d;
		end else if (push) begin
			skid_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign road1_red = out_q.lamps.r1_red;
	assign road1_amber = out_q.lamps.r1_yellow;
	assign road1_go = out_q.lamps.r1_green;
	assign road2_red = out_q.lamps.r2_red;
	assign road2_go = out_q.lamps.r2_green;
	assign phase = out_q.ph;
	assign request_pending = out_q.req;
	assign phase_changed = out_q.changed;

endmodule

// File: hdl/tlpc_checker.sv
module tlpc_checker import tlpc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       road1_red,
	input logic       road1_amber,
	input logic       road1_go,
	input logic       road2_red,
	input logic       road2_go,
	input logic [2:0] phase,
	input logic       request_pending,
	input logic       phase_changed
);

	// held result keeps its phase, change flag and pending request
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) &&
		$stable(phase_changed) && $stable(request_pending))
		else $error("stalled result changed");

	// never both greens, and at least one road red
	a_greens: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(road1_go && road2_go) && (road1_red || road2_red))
		else $error("conflicting lamp drives");

	// road1 green phase drives the road1 green lamps
	a_r1_green: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_R1_GREEN |->
		road1_go && road2_red && !road1_red && !road1_amber && !road2_go)
		else $error("road1 green lamps wrong");

	// leaving road1 green clears the request
	a_req_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_R1_YELLOW && phase_changed |-> !request_pending)
		else $error("request survived road1 green exit");

endmodule

bind traffic_light_pedestrian_controller tlpc_checker u_tlpc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.road1_red(road1_red),
	.road1_amber(road1_amber),
	.road1_go(road1_go),
	.road2_red(road2_red),
	.road2_go(road2_go),
	.phase(phase),
	.request_pending(request_pending),
	.phase_changed(phase_changed)
);

// File: tb/traffic_light_pedestrian_controller_tb.sv
module traffic_light_pedestrian_controller_tb import tlpc_pkg::*;;

	localparam int LIMIT = 1_500_000;
	localparam int N_RAND_SETS = 8;
	localparam int TICKS_PER_SET = 90;
	localparam int STEADY_TICKS = 100;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;
	typedef logic [4:0][CFG_W-1:0] cfg_set_t;

	typedef struct {
		row_kind_t kind;
		logic      btn;
		logic      typed;
		result_t   res;
		cfg_set_t  cfg;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic button_edge = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic road1_red, road1_amber, road1_go, road2_red, road2_go;
	logic [2:0] phase;
	logic request_pending, phase_changed;

	logic row_typed = 1'b0;
	result_t row_exp = '0;
	logic steady = 1'b0;

	int errors = 0;
	int ticks_sent = 0;
	int results_seen = 0;
	int cycles = 0;

	// predictor state and register copies
	logic [CFG_W-1:0] m_green = GREEN_RST;
	logic [CFG_W-1:0] m_min_green = MIN_GREEN_RST;
	logic [CFG_W-1:0] m_yellow = YELLOW_RST;
	logic [CFG_W-1:0] m_all_red = ALL_RED_RST;
	logic [CFG_W-1:0] m_debounce = DEBOUNCE_RST;
	phase_t m_phase = PH_R1_GREEN;
	timer_t m_in_phase = '0;
	timer_t m_since_press = '0;
	logic m_request = 1'b0;

	result_t lamp_q [$];
	dir_row_t dir_tab [$];

	traffic_light_pedestrian_controller u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_edge(button_edge),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.road1_red(road1_red),
		.road1_amber(road1_amber),
		.road1_go(road1_go),
		.road2_red(road2_red),
		.road2_go(road2_go),
		.phase(phase),
		.request_pending(request_pending),
		.phase_changed(phase_changed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic timer_t bump(input timer_t v);
		return (v == {TIMER_BITS{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic result_t step_lights(input logic btn);
		phase_t nxt;
		result_t r;
		nxt = m_phase;
		m_in_phase = bump(m_in_phase);
		m_since_press = bump(m_since_press);
		if (btn && m_since_press > m_debounce) begin
			m_request = 1'b1;
			m_since_press = '0;
		end
		case (m_phase)
			PH_R1_GREEN: begin
				if (m_in_phase >= m_green || (m_request && m_in_phase >= m_min_green)) begin
					m_request = 1'b0;
					nxt = PH_R1_YELLOW;
				end
			end
			PH_R1_YELLOW: if (m_in_phase >= m_yellow) nxt = PH_ALL_RED;
			PH_ALL_RED:   if (m_in_phase >= m_all_red) nxt = PH_R2_GREEN;
			PH_R2_GREEN:  if (m_in_phase >= m_green) nxt = PH_R2_YELLOW;
			PH_R2_YELLOW: if (m_in_phase >= m_yellow) nxt = PH_R1_GREEN;
			default:      nxt = PH_R1_GREEN;
		endcase
		r.changed = (nxt != m_phase);
		if (r.changed) begin
			m_phase = nxt;
			m_in_phase = '0;
		end
		case (m_phase)
			PH_R1_GREEN:  r.lamps = 5'b00110;
			PH_R1_YELLOW: r.lamps = 5'b01010;
			PH_ALL_RED:   r.lamps = 5'b10010;
			PH_R2_GREEN:  r.lamps = 5'b10001;
			PH_R2_YELLOW: r.lamps = 5'b11010;
			default:      r.lamps = '0;
		endcase
		r.ph = m_phase;
		r.req = m_request;
		return r;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		result_t want;
		result_t pred;
		if (!arst_n) begin
			lamp_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_GREEN:    m_green = cfg_wdata;
					REG_MIN_GRN:  m_min_green = cfg_wdata;
					REG_YELLOW:   m_yellow = cfg_wdata;
					REG_ALL_RED:  m_all_red = cfg_wdata;
					REG_DEBOUNCE: m_debounce = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				pred = step_lights(button_edge);
				lamp_q.push_back(row_typed ? row_exp : pred);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (lamp_q.size() == 0) begin
					$display("%0t: result with nothing expected, expected none actual phase %0d",
						$time, phase);
					errors++;
				end else begin
					want = lamp_q.pop_front();
					check_field("road1_red", want.lamps.r1_red, road1_red);
					check_field("road1_amber", want.lamps.r1_yellow, road1_amber);
					check_field("road1_go", want.lamps.r1_green, road1_go);
					check_field("road2_red", want.lamps.r2_red, road2_red);
					check_field("road2_go", want.lamps.r2_green, road2_go);
					check_field("phase", want.ph, phase);
					check_field("request_pending", want.req, request_pending);
					check_field("phase_changed", want.changed, phase_changed);
				end
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 20);
		cycles++;
		if (cycles > LIMIT) begin
			$display("traffic_light_pedestrian_controller_tb: errors");
			$finish;
		end
	end

	function automatic result_t lights(input logic [4:0] l, input phase_t p, input logic rq,
		input logic ch);
		result_t r;
		r = {l, p, rq, ch};
		return r;
	endfunction

	function automatic void add_tick(input logic btn, input logic typed, input result_t res);
		dir_row_t row;
		row.kind = ROW_TICK;
		row.btn = btn;
		row.typed = typed;
		row.res = res;
		row.cfg = '0;
		dir_tab.push_back(row);
	endfunction

	function automatic void add_cfg(input int g, input int mg, input int y, input int ar,
		input int db);
		dir_row_t row;
		row.kind = ROW_CFG;
		row.btn = 1'b0;
		row.typed = 1'b0;
		row.res = '0;
		row.cfg[REG_GREEN] = CFG_W'(g);
		row.cfg[REG_MIN_GRN] = CFG_W'(mg);
		row.cfg[REG_YELLOW] = CFG_W'(y);
		row.cfg[REG_ALL_RED] = CFG_W'(ar);
		row.cfg[REG_DEBOUNCE] = CFG_W'(db);
		dir_tab.push_back(row);
	endfunction

	task automatic send_tick(input logic btn, input logic typed, input result_t res);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 20)
			gap = $urandom_range(1, 2);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		button_edge <= btn;
		row_typed <= typed;
		row_exp <= res;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ticks_sent++;
	endtask

	task automatic apply_config(input cfg_set_t cfg);
		in_valid <= 1'b0;
		while (results_seen < ticks_sent) @(posedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_wdata <= cfg[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		cfg_set_t cfg;
		int press_pct;
		add_tick(1'b0, 1'b1, lights(5'b00110, PH_R1_GREEN, 1'b0, 1'b0));
		// press inside the debounce window after reset
		add_tick(1'b1, 1'b1, lights(5'b00110, PH_R1_GREEN, 1'b0, 1'b0));
		// zero durations: every phase lasts one tick
		add_cfg(0, 0, 0, 0, 0);
		add_tick(1'b0, 1'b1, lights(5'b01010, PH_R1_YELLOW, 1'b0, 1'b1));
		add_tick(1'b0, 1'b1, lights(5'b10010, PH_ALL_RED, 1'b0, 1'b1));
		add_tick(1'b0, 1'b1, lights(5'b10001, PH_R2_GREEN, 1'b0, 1'b1));
		add_tick(1'b0, 1'b1, lights(5'b11010, PH_R2_YELLOW, 1'b0, 1'b1));
		add_tick(1'b0, 1'b1, lights(5'b00110, PH_R1_GREEN, 1'b0, 1'b1));
		// press on road1 green, then a press on road1 yellow whose request is held through the other phases
		add_tick(1'b1, 1'b0, '0);
		add_tick(1'b1, 1'b0, '0);
		add_tick(1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b0, '0);
		// all registers at the top of their range
		add_cfg(65535, 65535, 65535, 65535, 65535);
		add_tick(1'b1, 1'b0, '0);
		add_tick(1'b1, 1'b0, '0);
		// minimum green shorter than green, with presses on alternate ticks
		add_cfg(6, 2, 1, 0, 3);
		for (int i = 0; i < 6; i++) add_tick(i[0], 1'b0, '0);
		// minimum green longer than green
		add_cfg(2, 7, 1, 1, 1);
		for (int i = 0; i < 4; i++) add_tick(~i[0], 1'b0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				apply_config(dir_tab[i].cfg);
			else
				send_tick(dir_tab[i].btn, dir_tab[i].typed, dir_tab[i].res);
		end

		for (int s = 0; s < N_RAND_SETS; s++) begin
			if (s == 5) begin
				for (int i = 0; i < 5; i++) cfg[i] = CFG_W'($urandom_range(0, 65535));
			end else begin
				cfg[REG_GREEN] = CFG_W'($urandom_range(0, 40));
				cfg[REG_MIN_GRN] = CFG_W'($urandom_range(0, 40));
				cfg[REG_YELLOW] = CFG_W'($urandom_range(0, 8));
				cfg[REG_ALL_RED] = CFG_W'($urandom_range(0, 8));
				cfg[REG_DEBOUNCE] = CFG_W'($urandom_range(0, 25));
			end
			apply_config(cfg);
			case (s % 4)
				0: press_pct = 5;
				1: press_pct = 20;
				2: press_pct = 50;
				default: press_pct = 90;
			endcase
			for (int i = 0; i < TICKS_PER_SET; i++)
				send_tick($urandom_range(0, 99) < press_pct, 1'b0, '0);
		end

		// long run with no idling on either side
		cfg[REG_GREEN] = 12;
		cfg[REG_MIN_GRN] = 4;
		cfg[REG_YELLOW] = 2;
		cfg[REG_ALL_RED] = 2;
		cfg[REG_DEBOUNCE] = 5;
		apply_config(cfg);
		steady <= 1'b1;
		for (int i = 0; i < STEADY_TICKS; i++)
			send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
		in_valid <= 1'b0;
		steady <= 1'b0;

		while (results_seen < ticks_sent) @(posedge clk);
		repeat (8) @(posedge clk);
		if (lamp_q.size() != 0) begin
			$display("%0t: results outstanding, expected 0 actual %0d", $time, lamp_q.size());
			errors++;
		end
		if (errors == 0)
			$display("traffic_light_pedestrian_controller_tb: clean");
		else
			$display("traffic_light_pedestrian_controller_tb: errors");
		$finish;
	end

endmodule
